@@ rtl/bsdpwm_pkg.sv @@
`default_nettype none

package bsdpwm_pkg;

  localparam int unsigned AngleW = 9;
  localparam int unsigned DutyW  = 7;
  localparam int unsigned SectW  = 3;
  localparam int unsigned RelW   = 6;

  localparam logic [DutyW-1:0]  FULL_DUTY   = 7'd100;
  localparam logic [DutyW-1:0]  COUNT_TOP   = 7'd99;
  localparam logic [AngleW-1:0] ANGLE_LIMIT = 9'd360;
  localparam logic [SectW-1:0]  LAST_SECTOR = 3'd5;

  typedef enum logic {
    KIND_ANGLE = 1'b0,
    KIND_TICK  = 1'b1
  } kind_t;

  // Phase levels, bit 0 is U, bit 1 is V and bit 2 is W.
  typedef logic [2:0] levels_t;

  typedef struct packed {
    logic [DutyW-1:0] u;
    logic [DutyW-1:0] v;
    logic [DutyW-1:0] w;
  } duty_set_t;

  function automatic levels_t sector_levels(input logic [SectW-1:0] sect);
    levels_t lev;
    case (sect)
      3'd0:    lev = 3'b001;
      3'd1:    lev = 3'b011;
      3'd2:    lev = 3'b010;
      3'd3:    lev = 3'b110;
      3'd4:    lev = 3'b100;
      3'd5:    lev = 3'b101;
      default: lev = 3'b001;
    endcase
    return lev;
  endfunction

  function automatic logic [AngleW-1:0] sector_base(input logic [SectW-1:0] sect);
    logic [AngleW-1:0] base;
    case (sect)
      3'd0:    base = 9'd0;
      3'd1:    base = 9'd60;
      3'd2:    base = 9'd120;
      3'd3:    base = 9'd180;
      3'd4:    base = 9'd240;
      3'd5:    base = 9'd300;
      default: base = 9'd0;
    endcase
    return base;
  endfunction

  function automatic logic [DutyW-1:0] phase_duty(input logic lev_a, input logic lev_b,
                                                  input logic [DutyW-1:0] ramp);
    logic [DutyW-1:0] duty;
    if (lev_a == lev_b) begin
      duty = lev_a ? FULL_DUTY : '0;
    end else if (lev_b) begin
      duty = ramp;
    end else begin
      duty = FULL_DUTY - ramp;
    end
    return duty;
  endfunction

endpackage

`default_nettype wire

@@ rtl/bsdpwm_if.sv @@
`default_nettype none

interface bsdpwm_in_if;
  import bsdpwm_pkg::*;

  logic              valid;
  logic              ready;
  logic              kind;
  logic [AngleW-1:0] angle_deg;

  modport source (output valid, output kind, output angle_deg, input ready);
  modport sink   (input valid, input kind, input angle_deg, output ready);
endinterface

interface bsdpwm_out_if;
  import bsdpwm_pkg::*;

  logic             valid;
  logic             ready;
  logic             pin_u;
  logic             pin_v;
  logic             pin_w;
  logic [DutyW-1:0] duty_u;
  logic [DutyW-1:0] duty_v;
  logic [DutyW-1:0] duty_w;
  logic             angle_error;

  modport source (output valid, output pin_u, output pin_v, output pin_w,
                  output duty_u, output duty_v, output duty_w, output angle_error,
                  input ready);
  modport sink   (input valid, input pin_u, input pin_v, input pin_w,
                  input duty_u, input duty_v, input duty_w, input angle_error,
                  output ready);
endinterface

`default_nettype wire

@@ rtl/bsdpwm_angle.sv @@
`default_nettype none

module bsdpwm_angle (
  input  logic [bsdpwm_pkg::AngleW-1:0] angle_deg,
  output bsdpwm_pkg::duty_set_t         duties,
  output logic                          angle_error
);
  import bsdpwm_pkg::*;

  logic [SectW-1:0]  sect_a;
  logic [SectW-1:0]  sect_b;
  logic [AngleW-1:0] rel_full;
  logic [RelW-1:0]   rel;
  logic [8:0]        rel_x5;
  logic [15:0]       prod;
  logic [DutyW-1:0]  ramp;
  levels_t           lev_a;
  levels_t           lev_b;

  always_comb begin
    if (angle_deg >= 9'd300) begin
      sect_a = 3'd5;
    end else if (angle_deg >= 9'd240) begin
      sect_a = 3'd4;
    end else if (angle_deg >= 9'd180) begin
      sect_a = 3'd3;
    end else if (angle_deg >= 9'd120) begin
      sect_a = 3'd2;
    end else if (angle_deg >= 9'd60) begin
      sect_a = 3'd1;
    end else begin
      sect_a = 3'd0;
    end
  end

  assign sect_b   = (sect_a == LAST_SECTOR) ? '0 : sect_a + 3'd1;
  assign rel_full = angle_deg - sector_base(sect_a);
  assign rel      = rel_full[RelW-1:0];

  // The ramp is rel * 5 / 3; division by three is a multiply by 171 / 512,
  // which is exact after truncation for every product up to 295.
  assign rel_x5 = {3'b000, rel} * 9'd5;
  assign prod   = {7'b0000000, rel_x5} * 16'd171;
  assign ramp   = prod[15:9];

  assign lev_a = sector_levels(sect_a);
  assign lev_b = sector_levels(sect_b);

  assign duties.u    = phase_duty(lev_a[0], lev_b[0], ramp);
  assign duties.v    = phase_duty(lev_a[1], lev_b[1], ramp);
  assign duties.w    = phase_duty(lev_a[2], lev_b[2], ramp);
  assign angle_error = (angle_deg >= ANGLE_LIMIT);

endmodule

`default_nettype wire

@@ rtl/bsdpwm_pwm.sv @@
`default_nettype none

module bsdpwm_pwm (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  tick,
  input  bsdpwm_pkg::duty_set_t duties,
  output bsdpwm_pkg::levels_t   pins_nxt
);
  import bsdpwm_pkg::*;

  logic [DutyW-1:0] count_r;
  logic [DutyW-1:0] count_nxt;
  levels_t          pins_r;
  levels_t          tick_pins;

  assign tick_pins[0] = !(duties.u > count_r);
  assign tick_pins[1] = !(duties.v > count_r);
  assign tick_pins[2] = !(duties.w > count_r);

  always_comb begin
    pins_nxt  = pins_r;
    count_nxt = count_r;
    if (tick) begin
      pins_nxt  = tick_pins;
      count_nxt = (count_r > COUNT_TOP) ? '0 : count_r + 7'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      pins_r  <= '0;
    end else begin
      count_r <= count_nxt;
      pins_r  <= pins_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/bldc_sector_duty_soft_pwm.sv @@
// Path: an input transaction is loaded into the input register at the accepting edge and
// passes to the result register when that register is empty or being read.
// Throughput: one transaction per cycle unless the result stalls, set by the single duty and
// counter update stage; a stalled result register holds one further transaction upstream.
// Reset: synchronous and active low; duties, PWM count and pins clear to zero.
`default_nettype none

module bldc_sector_duty_soft_pwm (
  input  logic         clk,
  input  logic         rst_n,
  bsdpwm_in_if.sink    in_ch,
  bsdpwm_out_if.source out_ch
);
  import bsdpwm_pkg::*;

  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic              s1_kind_r;
  logic [AngleW-1:0] s1_angle_r;

  logic              out_valid_r;
  logic              out_valid_nxt;
  levels_t           out_pins_r;
  duty_set_t         out_duty_r;
  logic              out_err_r;

  duty_set_t         duty_r;
  duty_set_t         duty_nxt;
  duty_set_t         angle_duties;
  logic              angle_err;
  levels_t           pins_nxt;

  logic              advance;
  logic              in_acc;
  logic              fire;
  logic              is_tick;
  logic              item_err;

  assign advance     = !out_valid_r || out_ch.ready;
  assign in_ch.ready = !s1_valid_r || advance;
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign fire        = s1_valid_r && advance;
  assign is_tick     = (s1_kind_r == KIND_TICK);
  assign item_err    = !is_tick && angle_err;

  bsdpwm_angle u_angle (
    .angle_deg   (s1_angle_r),
    .duties      (angle_duties),
    .angle_error (angle_err)
  );

  bsdpwm_pwm u_pwm (
    .clk      (clk),
    .rst_n    (rst_n),
    .tick     (fire && is_tick),
    .duties   (duty_r),
    .pins_nxt (pins_nxt)
  );

  always_comb begin
    duty_nxt = duty_r;
    if (fire && !is_tick && !angle_err) begin
      duty_nxt = angle_duties;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc) begin
      s1_valid_nxt = 1'b1;
    end else if (advance) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      duty_r      <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      duty_r      <= duty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r  <= in_ch.kind;
      s1_angle_r <= in_ch.angle_deg;
    end
    if (fire) begin
      out_pins_r <= pins_nxt;
      out_duty_r <= duty_nxt;
      out_err_r  <= item_err;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.pin_u       = out_pins_r[0];
  assign out_ch.pin_v       = out_pins_r[1];
  assign out_ch.pin_w       = out_pins_r[2];
  assign out_ch.duty_u      = out_duty_r.u;
  assign out_ch.duty_v      = out_duty_r.v;
  assign out_ch.duty_w      = out_duty_r.w;
  assign out_ch.angle_error = out_err_r;

endmodule

`default_nettype wire

@@ rtl/bsdpwm_chk.sv @@
`default_nettype none

module bsdpwm_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_valid,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [bsdpwm_pkg::DutyW-1:0] duty_u,
  input logic [bsdpwm_pkg::DutyW-1:0] duty_v,
  input logic [bsdpwm_pkg::DutyW-1:0] duty_w
);
  import bsdpwm_pkg::*;

  // A reset leaves no result transaction pending.
  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // An input transaction followed by a ready sink yields a result next cycle.
  a_flow: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready |=> out_valid)
    else $error("accepted transaction did not reach the result register");

  // Duties never leave the percent range.
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (duty_u <= FULL_DUTY) && (duty_v <= FULL_DUTY) && (duty_w <= FULL_DUTY))
    else $error("duty above full scale");

  a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result valid dropped while stalled");

  a_payload_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(duty_u) && $stable(duty_v) && $stable(duty_w))
    else $error("result payload changed while stalled");

endmodule

bind bldc_sector_duty_soft_pwm bsdpwm_chk u_bsdpwm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .duty_u    (out_ch.duty_u),
  .duty_v    (out_ch.duty_v),
  .duty_w    (out_ch.duty_w)
);

`default_nettype wire

@@ bench/tb_bldc_sector_duty_soft_pwm.sv @@
`default_nettype none

module tb_bldc_sector_duty_soft_pwm;
  import bsdpwm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned DRAIN_CYCLES = 10;
  localparam int unsigned SECTOR_SPAN = 60;
  localparam int unsigned SECTOR_NUM = 6;
  localparam logic [AngleW-1:0] ANGLE_MAX = 9'd511;
  localparam logic [AngleW-1:0] ANGLE_TOP_VALID = 9'd359;

  localparam levels_t SECTOR_PATTERN [SECTOR_NUM] = '{
    3'b001, 3'b011, 3'b010, 3'b110, 3'b100, 3'b101
  };

  typedef struct packed {
    levels_t          pins;
    logic [DutyW-1:0] duty_u;
    logic [DutyW-1:0] duty_v;
    logic [DutyW-1:0] duty_w;
    logic             angle_error;
  } pwm_result_t;

  logic clk = 1'b0;
  logic rst_n;

  bsdpwm_in_if  in_if();
  bsdpwm_out_if out_if();

  bldc_sector_duty_soft_pwm u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_if),
    .out_ch (out_if)
  );

  pwm_result_t      pending_pwm_results[$];
  logic [DutyW-1:0] duty_model [3];
  logic [DutyW-1:0] count_model;
  levels_t          pins_model;
  int unsigned      src_idle_pct;
  int unsigned      sink_idle_pct;
  int unsigned      mismatch_count;
  int unsigned      cycle_count;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("bldc_sector_duty_soft_pwm verification failed");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_if.ready = ($urandom_range(0, 99) >= sink_idle_pct);
  end

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatch_count++;
    $display("MISMATCH %s: got %0d, expected %0d (cycle %0d)", what, got, want, cycle_count);
  endtask

  function automatic pwm_result_t predict_pwm_step(input kind_t kind,
                                                   input logic [AngleW-1:0] angle);
    pwm_result_t res;
    int unsigned sect_a;
    int unsigned sect_b;
    int unsigned ramp;
    levels_t     lev_a;
    levels_t     lev_b;
    res = '0;
    if (kind == KIND_ANGLE) begin
      if (angle >= ANGLE_LIMIT) begin
        res.angle_error = 1'b1;
      end else begin
        sect_a = angle / SECTOR_SPAN;
        sect_b = (sect_a + 1 == SECTOR_NUM) ? 0 : sect_a + 1;
        ramp = ((angle - sect_a * SECTOR_SPAN) * 5) / 3;
        lev_a = SECTOR_PATTERN[sect_a];
        lev_b = SECTOR_PATTERN[sect_b];
        for (int i = 0; i < 3; i++) begin
          if (lev_a[i] == lev_b[i]) begin
            duty_model[i] = lev_a[i] ? FULL_DUTY : '0;
          end else if (lev_b[i]) begin
            duty_model[i] = DutyW'(ramp);
          end else begin
            duty_model[i] = FULL_DUTY - DutyW'(ramp);
          end
        end
      end
    end else begin
      for (int i = 0; i < 3; i++) begin
        pins_model[i] = !(duty_model[i] > count_model);
      end
      count_model = (count_model > COUNT_TOP) ? '0 : count_model + 1'b1;
    end
    res.pins = pins_model;
    res.duty_u = duty_model[0];
    res.duty_v = duty_model[1];
    res.duty_w = duty_model[2];
    return res;
  endfunction

  always @(posedge clk) begin
    pwm_result_t got;
    pwm_result_t want;
    if (rst_n && out_if.valid && out_if.ready) begin
      got.pins = {out_if.pin_w, out_if.pin_v, out_if.pin_u};
      got.duty_u = out_if.duty_u;
      got.duty_v = out_if.duty_v;
      got.duty_w = out_if.duty_w;
      got.angle_error = out_if.angle_error;
      if (pending_pwm_results.size() == 0) begin
        report_mismatch("unexpected transaction", 1, 0);
      end else begin
        want = pending_pwm_results.pop_front();
        if (got.pins[0] !== want.pins[0]) report_mismatch("pin_u", got.pins[0], want.pins[0]);
        if (got.pins[1] !== want.pins[1]) report_mismatch("pin_v", got.pins[1], want.pins[1]);
        if (got.pins[2] !== want.pins[2]) report_mismatch("pin_w", got.pins[2], want.pins[2]);
        if (got.duty_u !== want.duty_u) report_mismatch("duty_u", got.duty_u, want.duty_u);
        if (got.duty_v !== want.duty_v) report_mismatch("duty_v", got.duty_v, want.duty_v);
        if (got.duty_w !== want.duty_w) report_mismatch("duty_w", got.duty_w, want.duty_w);
        if (got.angle_error !== want.angle_error) begin
          report_mismatch("angle_error", got.angle_error, want.angle_error);
        end
      end
    end
  end

  // Entered and left just after a falling edge; valid stays high between back-to-back items.
  task automatic send_item(input kind_t kind, input logic [AngleW-1:0] angle);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid = 1'b1;
    in_if.kind = kind;
    in_if.angle_deg = angle;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    pending_pwm_results.push_back(predict_pwm_step(kind, angle));
    @(negedge clk);
  endtask

  task automatic wait_for_drain();
    in_if.valid = 1'b0;
    while (pending_pwm_results.size() != 0) @(negedge clk);
  endtask

  task automatic send_tick();
    send_item(KIND_TICK, AngleW'($urandom_range(0, ANGLE_MAX)));
  endtask

  task automatic test_ticks_after_reset();
    send_item(KIND_TICK, '0);
    send_item(KIND_TICK, ANGLE_MAX);
  endtask

  task automatic test_sector_boundaries();
    for (int s = 0; s < SECTOR_NUM; s++) begin
      send_item(KIND_ANGLE, AngleW'(s * SECTOR_SPAN));
      send_item(KIND_ANGLE, AngleW'(s * SECTOR_SPAN + SECTOR_SPAN - 1));
    end
    send_tick();
  endtask

  task automatic test_out_of_range_angle();
    send_item(KIND_ANGLE, 9'd180);
    send_item(KIND_ANGLE, ANGLE_LIMIT);
    send_item(KIND_ANGLE, ANGLE_MAX);
    send_item(KIND_ANGLE, 9'd400);
    send_tick();
    send_item(KIND_ANGLE, ANGLE_TOP_VALID);
  endtask

  // A full PWM period, so the count reaches 100 and wraps to zero.
  task automatic test_pwm_period();
    send_item(KIND_ANGLE, 9'd35);
    for (int i = 0; i < 103; i++) send_tick();
  endtask

  task automatic test_random_traffic(input int unsigned n_items);
    int unsigned sent;
    int unsigned pick;
    int unsigned burst;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 60) begin
        send_item(KIND_ANGLE, AngleW'($urandom_range(0, ANGLE_TOP_VALID)));
        burst = $urandom_range(1, 30);
        for (int i = 0; i < burst; i++) send_tick();
        sent += burst + 1;
      end else if (pick < 72) begin
        send_item(KIND_ANGLE, AngleW'($urandom_range(ANGLE_LIMIT, ANGLE_MAX)));
        sent++;
      end else if (pick < 86) begin
        send_item(KIND_ANGLE, AngleW'($urandom_range(0, ANGLE_TOP_VALID)));
        sent++;
      end else begin
        send_tick();
        sent++;
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.kind = KIND_ANGLE;
    in_if.angle_deg = '0;
    out_if.ready = 1'b0;
    duty_model = '{default: '0};
    count_model = '0;
    pins_model = '0;
    mismatch_count = 0;
    cycle_count = 0;
    src_idle_pct = 34;
    sink_idle_pct = 71;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;

    test_ticks_after_reset();
    test_sector_boundaries();
    test_out_of_range_angle();
    test_random_traffic(300);
    wait_for_drain();

    src_idle_pct = 71;
    sink_idle_pct = 34;
    test_pwm_period();
    test_random_traffic(300);
    wait_for_drain();

    src_idle_pct = 0;
    sink_idle_pct = 0;
    test_random_traffic(300);
    wait_for_drain();

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatch_count == 0 && pending_pwm_results.size() == 0) begin
      $display("bldc_sector_duty_soft_pwm verification clean");
    end else begin
      $display("bldc_sector_duty_soft_pwm verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/bsdpwm_pkg.sv
rtl/bsdpwm_if.sv
rtl/bsdpwm_angle.sv
rtl/bsdpwm_pwm.sv
rtl/bldc_sector_duty_soft_pwm.sv
rtl/bsdpwm_chk.sv
bench/tb_bldc_sector_duty_soft_pwm.sv
